@@ hw/rtl/ssp_pkg.sv @@
// Shared types and constants for the single-source shortest path block.
package ssp_pkg;

  localparam int NODE_W   = 4;
  localparam int COST_W   = 10;
  localparam int NODE_CAP = 16;

  localparam logic [COST_W-1:0] NO_LINK = 10'd999;

  localparam int CFG_DATA_W = 5;
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_SOURCE     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST = 5'd4;
  localparam logic [NODE_W-1:0]     SOURCE_RST     = 4'd0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] row_node;
    logic [NODE_W-1:0] col_node;
    logic [COST_W-1:0] link_cost;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] dest_node;
    logic [COST_W-1:0] distance;
    logic [NODE_W-1:0] pred_node;
    logic              reachable;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic load_cost;
    logic run_init;
    logic scan_en;
    logic next_round;
    logic out_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic out_done;
  } dp_status_t;

endpackage

@@ hw/rtl/ssp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssp_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/ssp_ctrl.sv @@
// Sequencer for matrix loads, search rounds and result output.
module ssp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  ssp_pkg::dp_status_t status,
  output ssp_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  import ssp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start && mode == MODE_RUN) begin
          cmd.run_init = 1'b1;
          state_next   = S_SCAN;
        end else if (start) begin
          cmd.load_cost = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        // a reachable unvisited node was found: settle it and relax its row
        if (status.found) begin
          cmd.next_round = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out_en = 1'b1;
        if (status.out_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ hw/rtl/ssp_dp.sv @@
// Datapath: configuration, distance/predecessor/visited registers, scan and output.
module ssp_dp #(
  parameter int MAX_NODES = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ssp_pkg::in_item_t                        item,
  input  logic                                     cfg_wr,
  input  logic                                     cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  ssp_pkg::ctrl_cmd_t                       cmd,
  output ssp_pkg::dp_status_t                      status,
  output logic                                     ram_wr_en,
  output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   ram_wr_addr,
  output logic [ssp_pkg::COST_W-1:0]               ram_wr_data,
  output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   ram_rd_addr,
  input  logic [ssp_pkg::COST_W-1:0]               ram_rd_data,
  output ssp_pkg::result_t                         result,
  output logic                                     result_valid
);

  import ssp_pkg::*;

  localparam int AW         = $clog2(MAX_NODES * MAX_NODES);
  localparam int NODES_USED = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int IW         = $clog2(NODES_USED);
  localparam int NW         = IW + 1;

  logic [CFG_DATA_W-1:0] node_count;
  logic [NODE_W-1:0]     source_node;

  logic [NW-1:0] n_calc;
  logic [IW-1:0] src_calc;
  logic [NW-1:0] n;
  logic [NW-1:0] n_m1;
  logic [IW-1:0] src;

  logic [COST_W-1:0] node_dist [NODES_USED];
  logic [IW-1:0]     pred      [NODES_USED];
  logic              visited   [NODES_USED];

  logic [IW-1:0]     u;
  logic [COST_W-1:0] du;
  logic [NW-1:0]     addr_idx;
  logic [IW-1:0]     proc_idx;
  logic              proc_valid;
  logic [COST_W-1:0] best;
  logic [IW-1:0]     best_idx;
  logic              found;
  logic [NW-1:0]     oi;

  logic [COST_W:0]   sum;
  logic              vis_i;
  logic              upd;
  logic [COST_W-1:0] new_d;
  logic              cand;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      source_node <= SOURCE_RST;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_NODE_COUNT) begin
        node_count <= cfg_data;
      end else begin
        source_node <= cfg_data[NODE_W-1:0];
      end
    end
  end

  // clamp node count and source into the usable range
  always_comb begin
    if (node_count < 5'd2) begin
      n_calc = NW'(2);
    end else if (32'(node_count) > NODES_USED) begin
      n_calc = NW'(NODES_USED);
    end else begin
      n_calc = NW'(node_count);
    end
    if (32'(source_node) >= 32'(n_calc)) begin
      src_calc = IW'(n_calc - NW'(1));
    end else begin
      src_calc = IW'(source_node);
    end
  end

  assign n_m1 = n - NW'(1);

  // cost matrix port
  assign ram_wr_en   = cmd.load_cost && (32'(item.row_node) < MAX_NODES) &&
                       (32'(item.col_node) < MAX_NODES);
  assign ram_wr_addr = AW'(item.row_node) * AW'(MAX_NODES) + AW'(item.col_node);
  assign ram_wr_data = item.link_cost;
  assign ram_rd_addr = AW'(u) * AW'(MAX_NODES) + AW'(addr_idx[IW-1:0]);

  // relax one element of row u; the min search runs on the updated value
  always_comb begin
    vis_i = visited[proc_idx];
    sum   = {1'b0, du} + {1'b0, ram_rd_data};
    upd   = !vis_i && (ram_rd_data < NO_LINK) && (sum < {1'b0, node_dist[proc_idx]});
    new_d = upd ? sum[COST_W-1:0] : node_dist[proc_idx];
    cand  = !vis_i && (new_d < best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else if (cmd.run_init || cmd.next_round) begin
      proc_valid <= 1'b0;
    end else if (cmd.scan_en) begin
      proc_valid <= (addr_idx < n);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      // first pass relaxes the source row with a zero base distance
      n        <= n_calc;
      src      <= src_calc;
      u        <= src_calc;
      du       <= '0;
      addr_idx <= '0;
      best     <= NO_LINK;
      found    <= 1'b0;
      oi       <= '0;
      for (int k = 0; k < NODES_USED; k++) begin
        node_dist[k] <= (IW'(k) == src_calc) ? '0 : NO_LINK;
        pred[k]      <= '0;
        visited[k]   <= (IW'(k) == src_calc);
      end
    end else if (cmd.next_round) begin
      u                 <= best_idx;
      du                <= best;
      visited[best_idx] <= 1'b1;
      addr_idx          <= '0;
      best              <= NO_LINK;
      found             <= 1'b0;
    end else begin
      if (cmd.scan_en) begin
        proc_idx <= addr_idx[IW-1:0];
        if (addr_idx < n) begin
          addr_idx <= addr_idx + NW'(1);
        end
      end
      if (proc_valid) begin
        if (upd) begin
          node_dist[proc_idx] <= new_d;
          pred[proc_idx]      <= u;
        end
        if (cand) begin
          best     <= new_d;
          best_idx <= proc_idx;
          found    <= 1'b1;
        end
      end
      if (cmd.out_en) begin
        oi <= oi + NW'(1);
      end
    end
  end

  assign status.scan_done = proc_valid && ({1'b0, proc_idx} == n_m1);
  assign status.found     = found;
  assign status.out_done  = (oi == n_m1);

  // result register, one per non-source node
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_en && (oi[IW-1:0] != src);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      result.dest_node   <= NODE_W'(oi[IW-1:0]);
      result.reachable   <= (node_dist[oi[IW-1:0]] < NO_LINK);
      result.distance    <= (node_dist[oi[IW-1:0]] < NO_LINK) ? node_dist[oi[IW-1:0]] :
                                                                NO_LINK;
      result.pred_node   <= (node_dist[oi[IW-1:0]] < NO_LINK) ? NODE_W'(pred[oi[IW-1:0]]) :
                                                                '0;
      result.last_result <= (oi == n_m1) ||
                            ((oi == n - NW'(2)) && ({1'b0, src} == n_m1));
    end
  end

endmodule

@@ hw/rtl/single_source_shortest_path.sv @@
// Single-source shortest path (array Dijkstra) over a loadable cost matrix.
// Usage:
//   Input: present item on the cycle start is high; it is taken when busy is low.
//   mode 0 writes link_cost at (row_node, col_node), no result.
//   mode 1 runs the search from source_node over node_count nodes (both clamped).
//   Config: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 node_count, 1 source_node); write only while the block is idle.
//   Results: one per non-source node in increasing node order, each shown for
//   one cycle with result_valid; last_result marks the final one. The receiver
//   cannot stall the block, so results leave one per cycle, with a gap at the source slot.
// Run: each round is one pass over a cost row read from the matrix RAM (one
//   read per cycle), then the controller settles the next node in its pick
//   state; rounds repeat while a reachable unvisited node is found, then the
//   results are output. busy is high throughout.
// Reset: node_count 4, source_node 0, controller idle. The cost matrix is
//   not cleared and must be written before use.
module single_source_shortest_path #(
  parameter int MAX_NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ssp_pkg::in_item_t              item,
  output ssp_pkg::result_t               result,
  output logic                           result_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ssp_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [COST_W-1:0] ram_wr_data;
  logic [AW-1:0]     ram_rd_addr;
  logic [COST_W-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;

  ssp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ssp_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .result       (result),
    .result_valid (result_valid)
  );

  ssp_ram #(
    .WIDTH (COST_W),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
